// ===== hdl/hsrp_pkg.sv =====
// ============================================================================
// hsrp_pkg: shared types and codes for the hashed set with random pick
// Command and status structs between the controller and the datapath.
// ============================================================================
package hsrp_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_PICK   = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // datapath operations requested by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,  // latch the input item
        OP_HASH_V    = 4'd2,  // start magnitude mod SLOTS of the key register (sel 1: last entry)
        OP_PROBE_RD  = 4'd3,  // read slot at probe pointer
        OP_PROBE_ADV = 4'd4,  // step probe pointer
        OP_INS_WR    = 4'd5,  // write new member into slot and dense array
        OP_DENSE_RD  = 4'd6,  // read dense entry at address register
        OP_REM_FIX   = 4'd7,  // move last entry, update its slot
        OP_SHIFT_RD  = 4'd8,  // read candidate slot of backward shift
        OP_SHIFT_HASH= 4'd9,  // hash member of candidate
        OP_SHIFT_MV  = 4'd10, // move candidate into gap
        OP_SHIFT_ADV = 4'd11, // step candidate pointer
        OP_CLR_GAP   = 4'd12, // clear final gap
        OP_DIV_START = 4'd13, // start draw mod count
        OP_CLEAR     = 4'd14  // clearing pass step
    } hsrp_op_t;

    typedef struct packed {
        hsrp_op_t   op;
        logic [1:0] sel;     // sub-select: key source / probe target
    } hsrp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       unit_busy;   // divider or home slot unit busy
        logic       slot_occ;    // occupied bit of the slot just read
        logic       slot_hit;    // member of slot just read equals key
        logic       probe_wrap;  // probe walked all slots
        logic       movable;     // shift candidate may fill the gap
        logic       count_zero;
        logic       count_full;
        logic       clear_done;
    } hsrp_stat_t;

endpackage

// ===== hdl/hsrp_ram.sv =====
// ============================================================================
// hsrp_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ============================================================================
module hsrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/hsrp_div.sv =====
// ============================================================================
// hsrp_div: restoring remainder unit
// One quotient bit per cycle: remainder of an NW-bit dividend by a divisor.
// ============================================================================
module hsrp_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], num_reg[NW-1]};
        if (start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NW-2:0], 1'b0};
            rem_next = (trial >= {1'b0, den_reg}) ? trial - {1'b0, den_reg} : trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg[DW-1:0];
endmodule

// ===== hdl/hsrp_datapath.sv =====
// ============================================================================
// hsrp_datapath: slot table, dense array, probe pointers and remainder units
// Executes one controller command per cycle.
// ============================================================================
module hsrp_datapath #(
    parameter int SLOTS    = 1021,
    parameter int CAPACITY = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hsrp_pkg::hsrp_cmd_t cmd,
    output hsrp_pkg::hsrp_stat_t stat,
    input  logic [1:0]         in_action,
    input  logic [31:0]        in_value,
    input  logic [30:0]        in_draw,
    output logic [31:0]        picked
);
    import hsrp_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = (SW > CW) ? SW : CW;
    localparam int SLOT_BITS = 1 + 32 + PW;
    // floor(2^32 / SLOTS); quotient estimate below is low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);

    // slot word: {occupied, member, position}; the clearing pass zeroes it
    logic [SW-1:0]        s_addr;
    logic                 s_we;
    logic [SLOT_BITS-1:0] s_wdata, s_rdata;
    logic [PW-1:0]        d_addr;
    logic                 d_we;
    logic [31:0]          d_wdata, d_rdata;

    hsrp_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_slots (
        .aclk(aclk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
    );
    hsrp_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_dense (
        .aclk(aclk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );

    logic [1:0]    act_reg, act_next;
    logic [31:0]   key_reg, key_next;      // value being probed
    logic [31:0]   val_reg, val_next;      // input value
    logic [30:0]   draw_reg, draw_next;
    logic [31:0]   last_reg, last_next;    // last dense entry
    logic [PW-1:0] pos_reg, pos_next;      // freed dense position
    logic [SW-1:0] ptr_reg, ptr_next;      // probe / candidate pointer
    logic [SW-1:0] gap_reg, gap_next;
    logic [SW-1:0] hit_reg, hit_next;      // slot where key was found
    logic [SW:0]   walk_reg, walk_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW:0]   clr_reg, clr_next;

    logic          div_start;
    logic [31:0]   div_num;
    logic [DW-1:0] div_den, div_rem;
    logic          div_busy;

    hsrp_div #(.NW(32), .DW(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .rem(div_rem)
    );

    logic          s_occ;
    logic [31:0]   s_mem;
    logic [PW-1:0] s_pos;
    logic [SW-1:0] ptr_inc;
    logic [SW-1:0] home;
    logic [31:0]   key_mag;

    // home slot unit: multiply by reciprocal, multiply back, one correction
    logic          hash_start;
    logic [1:0]    hcnt_reg, hcnt_next;
    logic [31:0]   hx_reg, hx_next;
    logic [31:0]   hq_reg, hq_next;
    logic [31:0]   hm_reg, hm_next;
    logic [31:0]   hrem_reg, hrem_next;
    logic [63:0]   h_prod;
    logic [31:0]   h_diff;

    assign s_occ   = s_rdata[SLOT_BITS-1];
    assign s_mem   = s_rdata[PW +: 32];
    assign s_pos   = s_rdata[PW-1:0];
    assign ptr_inc = (ptr_reg == SW'(SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
    assign home    = hrem_reg[SW-1:0];

    // pick the magnitude source: key register, last entry or member just read
    always_comb begin
        logic [31:0] src;
        if (cmd.op == OP_SHIFT_HASH) begin
            src = s_mem;
        end else if (cmd.op == OP_HASH_V && cmd.sel == 2'd1) begin
            src = last_reg;
        end else begin
            src = key_reg;
        end
        key_mag = src[31] ? (32'd0 - src) : src;
    end

    assign hash_start = (cmd.op == OP_HASH_V) || (cmd.op == OP_SHIFT_HASH);
    assign h_prod     = {32'd0, hx_reg} * {32'd0, RECIP};
    assign h_diff     = hx_reg - hm_reg;

    always_comb begin
        hcnt_next = hcnt_reg;
        hx_next   = hx_reg;
        hq_next   = hq_reg;
        hm_next   = hm_reg;
        hrem_next = hrem_reg;
        if (hash_start) begin
            hx_next   = key_mag;
            hcnt_next = 2'd3;
        end else if (hcnt_reg != 2'd0) begin
            hcnt_next = hcnt_reg - 1'b1;
            unique case (hcnt_reg)
                2'd3: hq_next = h_prod[63:32];
                2'd2: hm_next = hq_reg * 32'(SLOTS);
                2'd1: hrem_next = (h_diff >= 32'(SLOTS)) ? h_diff - 32'(SLOTS) : h_diff;
                default: begin
                end
            endcase
        end
    end

    assign div_start = (cmd.op == OP_DIV_START);
    assign div_num   = {1'b0, draw_reg};
    assign div_den   = DW'(count_reg);

    always_comb begin
        act_next   = act_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        draw_next  = draw_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        ptr_next   = ptr_reg;
        gap_next   = gap_reg;
        hit_next   = hit_reg;
        walk_next  = walk_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        s_addr     = ptr_reg;
        s_we       = 1'b0;
        s_wdata    = '0;
        d_addr     = pos_reg;
        d_we       = 1'b0;
        d_wdata    = last_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                act_next  = in_action;
                key_next  = in_value;
                val_next  = in_value;
                draw_next = in_draw;
            end
            OP_HASH_V: begin
                // sel 1: probe for the last dense entry
                if (cmd.sel == 2'd1) begin
                    key_next = last_reg;
                end
            end
            OP_PROBE_RD: begin
                // sel 1: first read after the hash, take the home slot
                if (cmd.sel == 2'd1) begin
                    ptr_next  = home;
                    walk_next = '0;
                    s_addr    = home;
                end
            end
            OP_PROBE_ADV: begin
                ptr_next  = ptr_inc;
                s_addr    = ptr_inc;
                walk_next = walk_reg + 1'b1;
            end
            OP_INS_WR: begin
                s_we    = 1'b1;
                s_wdata = {1'b1, val_reg, count_reg[PW-1:0]};
                d_addr  = count_reg[PW-1:0];
                d_we    = 1'b1;
                d_wdata = val_reg;
                count_next = count_reg + 1'b1;
            end
            OP_DENSE_RD: begin
                // sel 0: last entry; sel 1: picked index, held on the address
                if (cmd.sel == 2'd0) begin
                    d_addr   = PW'(count_reg - 1'b1);
                    hit_next = ptr_reg;
                    pos_next = s_pos;
                end else begin
                    d_addr   = div_rem[PW-1:0];
                    pos_next = div_rem[PW-1:0];
                end
            end
            OP_REM_FIX: begin
                // sel 0: latch last entry; sel 1: rewrite its slot and dense spot
                if (cmd.sel == 2'd0) begin
                    last_next = d_rdata;
                end else begin
                    s_we    = 1'b1;
                    s_wdata = {1'b1, s_mem, pos_reg};
                    d_we    = 1'b1;
                    count_next = count_reg - 1'b1;
                    gap_next = hit_reg;
                    ptr_next = hit_reg;
                    walk_next = '0;
                end
            end
            OP_SHIFT_ADV: begin
                ptr_next  = ptr_inc;
                s_addr    = ptr_inc;
                walk_next = walk_reg + 1'b1;
            end
            OP_SHIFT_HASH: begin
                key_next = s_mem;  // hold candidate word
                last_next = {{(32-PW){1'b0}}, s_pos};
            end
            OP_SHIFT_MV: begin
                s_addr   = gap_reg;
                s_we     = 1'b1;
                s_wdata  = {1'b1, key_reg, last_reg[PW-1:0]};
                gap_next = ptr_reg;
            end
            OP_CLR_GAP: begin
                s_addr  = gap_reg;
                s_we    = 1'b1;
                s_wdata = '0;
            end
            OP_CLEAR: begin
                s_addr   = clr_reg[SW-1:0];
                s_we     = 1'b1;
                s_wdata  = '0;
                clr_next = clr_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            clr_reg   <= '0;
            hcnt_reg  <= '0;
        end else begin
            count_reg <= count_next;
            clr_reg   <= clr_next;
            hcnt_reg  <= hcnt_next;
        end
        act_reg  <= act_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        draw_reg <= draw_next;
        last_reg <= last_next;
        pos_reg  <= pos_next;
        ptr_reg  <= ptr_next;
        gap_reg  <= gap_next;
        hit_reg  <= hit_next;
        walk_reg <= walk_next;
        hx_reg   <= hx_next;
        hq_reg   <= hq_next;
        hm_reg   <= hm_next;
        hrem_reg <= hrem_next;
    end

    // backward shift: candidate at ptr, home k, gap g
    logic mv;
    always_comb begin
        if (ptr_reg > gap_reg) begin
            mv = (home <= gap_reg) || (home > ptr_reg);
        end else begin
            mv = (home <= gap_reg) && (home > ptr_reg);
        end
    end

    assign stat.action     = act_reg;
    assign stat.unit_busy  = div_busy || (hcnt_reg != 2'd0);
    assign stat.slot_occ   = s_occ;
    assign stat.slot_hit   = (s_mem == key_reg);
    assign stat.probe_wrap = (walk_reg == (SW+1)'(SLOTS));
    assign stat.movable    = mv;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg >= CW'(CAPACITY));
    assign stat.clear_done = (clr_reg == (SW+1)'(SLOTS));
    assign picked          = d_rdata;
endmodule

// ===== hdl/hsrp_ctrl.sv =====
// ============================================================================
// hsrp_ctrl: sequencer for insert, remove and random pick
// Issues datapath commands and drives the stream handshakes.
// ============================================================================
module hsrp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hsrp_pkg::hsrp_stat_t stat,
    output hsrp_pkg::hsrp_cmd_t  cmd,
    input  logic                 in_fire,
    output logic                 in_ready,
    output logic                 res_load,
    output logic [1:0]           res_status,
    output logic                 res_pick,
    input  logic                 out_free
);
    import hsrp_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_HASH   = 16'h0004,
        S_HWAIT  = 16'h0008,
        S_PRD    = 16'h0010,
        S_PCHK   = 16'h0020,
        S_LRD    = 16'h0040,
        S_LLAT   = 16'h0080,
        S_LHASH  = 16'h0100,
        S_LFIX   = 16'h0200,
        S_SADV   = 16'h0400,
        S_SCHK   = 16'h0800,
        S_SHWAIT = 16'h1000,
        S_DWAIT  = 16'h2000,
        S_PICK   = 16'h4000,
        S_DONE   = 16'h8000
    } state_t;

    state_t     state_reg, state_next;
    logic       last_reg, last_next;   // probing for the last dense entry
    logic       first_reg, first_next; // first read after a hash
    logic [1:0] st_reg, st_next;
    logic       pk_reg, pk_next;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        first_next = first_reg;
        st_next    = st_reg;
        pk_next    = pk_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = 2'd0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done) begin
                    cmd.op     = OP_NONE;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = out_free;
                if (in_fire) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                last_next = 1'b0;
                st_next   = ST_MISS;
                pk_next   = 1'b0;
                if (stat.action == ACT_PICK) begin
                    if (stat.count_zero) begin
                        state_next = S_DONE;
                    end else begin
                        cmd.op     = OP_DIV_START;
                        state_next = S_DWAIT;
                    end
                end else if (stat.action == ACT_INSERT || stat.action == ACT_REMOVE) begin
                    cmd.op     = OP_HASH_V;
                    state_next = S_HWAIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_HWAIT: begin
                if (!stat.unit_busy) begin
                    cmd.op     = OP_PROBE_RD;
                    cmd.sel    = 2'd1;
                    state_next = S_PCHK;
                end
            end
            S_PCHK: begin
                // data of slot at ptr is valid now
                if (stat.probe_wrap) begin
                    // no free slot, no match
                    st_next    = (stat.action == ACT_INSERT) ? ST_FULL : ST_MISS;
                    state_next = last_reg ? S_SADV : S_DONE;
                end else if (!stat.slot_occ) begin
                    if (last_reg) begin
                        state_next = S_SADV;
                    end else if (stat.action == ACT_INSERT) begin
                        if (stat.count_full) begin
                            st_next = ST_FULL;
                        end else begin
                            cmd.op  = OP_INS_WR;
                            st_next = ST_DONE;
                        end
                        state_next = S_DONE;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (stat.slot_hit) begin
                    if (last_reg) begin
                        state_next = S_LFIX;
                    end else if (stat.action == ACT_INSERT) begin
                        state_next = S_DONE;
                    end else begin
                        cmd.op     = OP_DENSE_RD;
                        state_next = S_LRD;
                    end
                end else begin
                    cmd.op     = OP_PROBE_ADV;
                    state_next = S_PRD;
                end
            end
            S_PRD: begin
                state_next = S_PCHK;
            end
            S_LRD: begin
                cmd.op     = OP_REM_FIX;
                state_next = S_LLAT;
            end
            S_LLAT: begin
                cmd.op     = OP_HASH_V;
                cmd.sel    = 2'd1;
                last_next  = 1'b1;
                state_next = S_HWAIT;
            end
            S_LFIX: begin
                cmd.op     = OP_REM_FIX;
                cmd.sel    = 2'd1;
                st_next    = ST_DONE;
                state_next = S_LHASH;
            end
            S_LHASH: begin
                cmd.op     = OP_SHIFT_ADV;
                first_next = 1'b1;
                state_next = S_SCHK;
            end
            S_SADV: begin
                // last entry's slot absent: still finish the removal
                state_next = S_LFIX;
            end
            S_SCHK: begin
                if (!stat.slot_occ || (!first_reg && stat.probe_wrap)) begin
                    cmd.op     = OP_CLR_GAP;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_SHIFT_HASH;
                    state_next = S_SHWAIT;
                end
                first_next = 1'b0;
            end
            S_SHWAIT: begin
                if (!stat.unit_busy) begin
                    if (stat.movable) begin
                        cmd.op = OP_SHIFT_MV;
                        state_next = S_PICK;
                    end else begin
                        cmd.op     = OP_SHIFT_ADV;
                        state_next = S_SCHK;
                    end
                end
            end
            S_PICK: begin
                if (stat.action == ACT_PICK) begin
                    st_next    = ST_DONE;
                    pk_next    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_SHIFT_ADV;
                    state_next = S_SCHK;
                end
            end
            S_DWAIT: begin
                if (!stat.unit_busy) begin
                    cmd.op     = OP_DENSE_RD;
                    cmd.sel    = 2'd1;
                    state_next = S_PICK;
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            last_reg  <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            first_reg <= first_next;
        end
        st_reg <= st_next;
        pk_reg <= pk_next;
    end

    assign res_load   = (state_reg == S_DONE);
    assign res_status = st_reg;
    assign res_pick   = pk_reg;
endmodule

// ===== hdl/hashed_set_with_random_pick_top.sv =====
// ============================================================================
// hashed_set_with_random_pick_top: set of 32-bit values with random pick
// Linear-probing hash table plus dense member array.
// ============================================================================
// One item at a time. After reset a clearing pass writes every slot before
// the first item is taken. The home slot comes from a reciprocal-multiply
// remainder unit. Insert probes slot by slot from the home slot; remove runs
// a second probe for the last member, then a backward-shift walk over the
// examined slots, moving entries into the gap. Random pick takes the
// bit-serial remainder of the draw by the member count.
// The result is held in an output register; a new item is taken only when
// that register is empty or being read out in the same cycle.
module hashed_set_with_random_pick_top #(
    parameter int SLOTS    = 1021,
    parameter int CAPACITY = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // item_value[31:0], random_draw[62:32], pad
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // status[1:0], picked_value[33:2], pad
);
    import hsrp_pkg::*;
    hsrp_cmd_t  cmd;
    hsrp_stat_t stat;
    logic       res_load, res_pick;
    logic [1:0] res_status;
    logic [31:0] picked;
    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] value_reg;

    hsrp_datapath #(.SLOTS(SLOTS), .CAPACITY(CAPACITY)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_action(s_tuser), .in_value(s_tdata[31:0]), .in_draw(s_tdata[62:32]),
        .picked(picked)
    );

    hsrp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .stat(stat), .cmd(cmd),
        .in_fire(s_tvalid && s_tready), .in_ready(s_tready),
        .res_load(res_load), .res_status(res_status), .res_pick(res_pick),
        .out_free(!valid_reg || m_tready)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (res_load) begin
            status_reg <= res_status;
            value_reg  <= res_pick ? picked : 32'd0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, value_reg, status_reg};
endmodule
